>>> hw/rtl/alp_pkg.sv
// shared types and constants of the audio peak limiter
`timescale 1ns / 1ps
`default_nettype none

package alp_pkg;

   localparam int LANES      = 8;
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 25;
   localparam int COEFF_W    = 24;
   localparam int CEIL_W     = 15;
   localparam int CHAN_W     = 4;
   localparam int IN_W       = LANES * SAMPLE_W;
   localparam int OUT_BITS   = LANES * SAMPLE_W + GAIN_W;
   localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;
   localparam int GAIN_LSB   = LANES * SAMPLE_W;
   localparam int DIV_STEPS  = 24;
   localparam int CNT_W      = 5;
   localparam int LANE_IDX_W = $clog2(LANES);
   localparam int MUL_W      = 26;
   localparam int ACC_W      = 2 * MUL_W;

   localparam logic [GAIN_W-1:0]  UNITY_GAIN = 25'h100_0000;
   localparam logic [ACC_W-1:0]   HALF_LSB   = 52'h80_0000;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_ENABLE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CEILING  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS = 4'd3;

   localparam logic               RST_ENABLE   = 1'b1;
   localparam logic [CEIL_W-1:0]  RST_CEILING  = 15'd31656;
   localparam logic [COEFF_W-1:0] RST_RELEASE  = 24'd16770227;
   localparam logic [CHAN_W-1:0]  RST_CHANNELS = 4'd2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic               enable;
      logic [CEIL_W-1:0]  ceiling;
      logic [COEFF_W-1:0] coeff;
      logic [CHAN_W-1:0]  channels;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic peak_step;
      logic div_init;
      logic div_step;
      logic gain_a;
      logic gain_b;
      logic gain_c;
      logic scale_step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic bypass;
      logic peak_last;
      logic need_div;
      logic div_last;
      logic snap;
      logic scale_last;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/alp_dpath.sv
// datapath of the audio peak limiter: peak search, divider, gain smoother, lane scaling
`timescale 1ns / 1ps
`default_nettype none

module alp_dpath #(
   parameter int MAX_CHANNELS = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire alp_pkg::cmd_type          cmd,
   input  wire alp_pkg::cfg_type          cfg,
   input  wire logic [alp_pkg::IN_W-1:0]  in_data,
   output alp_pkg::status_type            status,
   output logic [alp_pkg::OUT_W-1:0]      out_data
);
   import alp_pkg::*;

   sample_type                samp_ff [LANES];
   logic [SAMPLE_W-1:0]       lane_out_ff [LANES];
   logic                      byp_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [SAMPLE_W:0]         peak_ff;
   logic [SAMPLE_W:0]         rem_ff;
   logic [DIV_STEPS-1:0]      quo_ff;
   logic [GAIN_W-1:0]         g_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [OUT_W-1:0]          out_ff;
   logic [OUT_W-1:0]          out_in;

   logic [CNT_W-1:0]          n_eff;
   logic [LANE_IDX_W-1:0]     lane_rd;
   logic [LANE_IDX_W-1:0]     lane_wr;
   sample_type                cur_samp;
   logic [SAMPLE_W:0]         abs_w;
   logic [SAMPLE_W+1:0]       rem2;
   logic                      need_div;
   logic [GAIN_W-1:0]         target_w;
   logic                      snap;
   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;
   logic signed [ACC_W-1:0]   product;
   logic [ACC_W-1:0]          gsum;
   logic [GAIN_W:0]           gfin;
   logic signed [ACC_W-1:0]   rnd;
   logic signed [ACC_W-25:0]  yv;
   logic signed [ACC_W-25:0]  ceil_pos;
   logic signed [ACC_W-25:0]  ceil_neg;
   logic [SAMPLE_W-1:0]       y_clip;

   always_comb begin
      if (cfg.channels == '0) begin
         n_eff = CNT_W'(1);
      end else if ({1'b0, cfg.channels} > CNT_W'(MAX_CHANNELS)) begin
         n_eff = CNT_W'(MAX_CHANNELS);
      end else begin
         n_eff = {1'b0, cfg.channels};
      end
   end

   assign lane_rd  = cnt_ff[LANE_IDX_W-1:0];
   assign lane_wr  = lane_rd - LANE_IDX_W'(1);
   assign cur_samp = samp_ff[lane_rd];
   assign abs_w    = cur_samp[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {cur_samp[SAMPLE_W-1], cur_samp})
                                          : {1'b0, cur_samp};
   assign rem2     = {rem_ff, 1'b0};
   assign need_div = peak_ff > {2'b00, cfg.ceiling};
   assign target_w = need_div ? {1'b0, quo_ff} : UNITY_GAIN;
   assign snap     = target_w < g_ff;

   always_comb begin
      priority if (cmd.gain_a) begin
         mul_a = $signed({2'b00, cfg.coeff});
         mul_b = $signed({1'b0, g_ff});
      end else if (cmd.gain_b) begin
         mul_a = $signed({1'b0, UNITY_GAIN - {1'b0, cfg.coeff}});
         mul_b = $signed({1'b0, target_w});
      end else begin
         mul_a = $signed({{(MUL_W-SAMPLE_W){cur_samp[SAMPLE_W-1]}}, cur_samp});
         mul_b = $signed({1'b0, g_ff});
      end
   end

   assign product  = mul_a * mul_b;
   assign gsum     = acc_ff + HALF_LSB;
   assign gfin     = gsum[GAIN_W+24:24];
   assign rnd      = acc_ff + $signed(HALF_LSB);
   assign yv       = rnd[ACC_W-1:24];
   assign ceil_pos = $signed({{(ACC_W-24-CEIL_W){1'b0}}, cfg.ceiling});
   assign ceil_neg = -ceil_pos;

   always_comb begin
      if (yv > ceil_pos) begin
         y_clip = ceil_pos[SAMPLE_W-1:0];
      end else if (yv < ceil_neg) begin
         y_clip = ceil_neg[SAMPLE_W-1:0];
      end else begin
         y_clip = yv[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      out_in = '0;
      for (int i = 0; i < LANES; i++) begin
         out_in[i*SAMPLE_W +: SAMPLE_W] = byp_ff ? samp_ff[i] : lane_out_ff[i];
      end
      out_in[GAIN_LSB +: GAIN_W] = byp_ff ? UNITY_GAIN : g_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_ff <= UNITY_GAIN;
      end else if (cmd.gain_a && snap) begin
         g_ff <= target_w;
      end else if (cmd.gain_c) begin
         g_ff <= (gfin > {1'b0, UNITY_GAIN}) ? UNITY_GAIN : gfin[GAIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int i = 0; i < LANES; i++) begin
            samp_ff[i] <= in_data[i*SAMPLE_W +: SAMPLE_W];
         end
         byp_ff  <= ~cfg.enable;
         cnt_ff  <= '0;
         peak_ff <= '0;
      end
      if (cmd.peak_step) begin
         if (abs_w > peak_ff) begin
            peak_ff <= abs_w;
         end
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.div_init) begin
         rem_ff <= {2'b00, cfg.ceiling};
         quo_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem2 >= {1'b0, peak_ff}) begin
            rem_ff <= (SAMPLE_W+1)'(rem2 - {1'b0, peak_ff});
            quo_ff <= {quo_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_ff <= rem2[SAMPLE_W:0];
            quo_ff <= {quo_ff[DIV_STEPS-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.gain_a) begin
         cnt_ff <= '0;
         acc_ff <= product;
      end
      if (cmd.gain_b) begin
         acc_ff <= acc_ff + product;
      end
      if (cmd.scale_step) begin
         acc_ff <= product;
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff != '0) begin
            lane_out_ff[lane_wr] <= (cnt_ff <= n_eff) ? y_clip : '0;
         end
      end
      if (cmd.load) begin
         out_ff <= out_in;
      end
   end

   assign status.bypass     = byp_ff;
   assign status.peak_last  = cnt_ff == (n_eff - CNT_W'(1));
   assign status.need_div   = need_div;
   assign status.div_last   = cnt_ff == CNT_W'(DIV_STEPS - 1);
   assign status.snap       = snap;
   assign status.scale_last = cnt_ff == CNT_W'(LANES);
   assign out_data          = out_ff;

`ifndef SYNTHESIS
   a_rem_below_peak: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < peak_ff)
      else $error("divider remainder not below divisor");

   a_snap_to_target: assert property (@(posedge clock) disable iff (reset)
      (cmd.gain_a && snap) |=> g_ff == $past(target_w))
      else $error("attack did not take target gain");

   a_release_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.gain_c |=> g_ff <= target_w)
      else $error("release gain passed target");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/alp_ctrl.sv
// controller state machine of the audio peak limiter
`timescale 1ns / 1ps
`default_nettype none

module alp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire alp_pkg::status_type  status,
   output alp_pkg::cmd_type          cmd
);
   import alp_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_PEAK   = 9'b000000010,
      ST_PREP   = 9'b000000100,
      ST_DIV    = 9'b000001000,
      ST_GAIN_A = 9'b000010000,
      ST_GAIN_B = 9'b000100000,
      ST_GAIN_C = 9'b001000000,
      ST_SCALE  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PEAK;
            end
         end
         ST_PEAK: begin
            if (status.bypass) begin
               state_in = ST_DONE;
            end else begin
               cmd.peak_step = 1'b1;
               if (status.peak_last) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            cmd.div_init = 1'b1;
            state_in     = status.need_div ? ST_DIV : ST_GAIN_A;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_GAIN_A;
            end
         end
         ST_GAIN_A: begin
            cmd.gain_a = 1'b1;
            state_in   = status.snap ? ST_SCALE : ST_GAIN_B;
         end
         ST_GAIN_B: begin
            cmd.gain_b = 1'b1;
            state_in   = ST_GAIN_C;
         end
         ST_GAIN_C: begin
            cmd.gain_c = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale_step = 1'b1;
            if (status.scale_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == ST_PEAK)
      else $error("accepted transaction did not start peak search");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded while holding a pending transaction");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && status.div_last) |=> state_ff == ST_GAIN_A)
      else $error("divider did not hand over to gain update");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/audio_peak_limiter.sv
// top level of the audio peak limiter: config registers, controller and datapath
// a frame is accepted only in idle; the 24-step restoring divider runs only when the peak of the
// n active lanes exceeds the ceiling, and a disabled block skips peak search and scaling
// no new frame is taken until the last one is loaded into the result register; the divider
// and the one multiplier shared by the release smoother and the eight lane scalings set the pace
// reset: synchronous, registers return to their defaults and the stored gain to unity
`timescale 1ns / 1ps
`default_nettype none

module audio_peak_limiter #(
   parameter int MAX_CHANNELS = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // sample_0 .. sample_7, 16 bits each
   input  wire logic [alp_pkg::IN_W-1:0]        req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // limited_0 .. limited_7 16 bits each, applied_gain 25 bits, zero pad
   output logic [alp_pkg::OUT_W-1:0]            rsp_tdata,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [alp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [alp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import alp_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   cmd_type    cmd;
   status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ENABLE:   cfg_in.enable   = csr_data[0];
            REG_CEILING:  cfg_in.ceiling  = csr_data[CEIL_W-1:0];
            REG_RELEASE:  cfg_in.coeff    = csr_data[COEFF_W-1:0];
            REG_CHANNELS: cfg_in.channels = csr_data[CHAN_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable   <= RST_ENABLE;
         cfg_ff.ceiling  <= RST_CEILING;
         cfg_ff.coeff    <= RST_RELEASE;
         cfg_ff.channels <= RST_CHANNELS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   alp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   alp_dpath #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg_ff),
      .in_data  (req_tdata),
      .status   (status),
      .out_data (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> sim/audio_peak_limiter_tb.sv
// self-checking testbench of the audio peak limiter: directed script, then random phases
`timescale 1ns / 1ps

module audio_peak_limiter_tb;
   import alp_pkg::*;

   typedef logic [LANES-1:0][SAMPLE_W-1:0] frame_type;

   // same layout as rsp_tdata: limited_0 in the lowest bits, then applied_gain, then pad
   typedef struct packed {
      logic [OUT_W-OUT_BITS-1:0]          pad;
      logic [GAIN_W-1:0]                  gain;
      logic [LANES-1:0][SAMPLE_W-1:0]     lane;
   } limited_frame_type;

   typedef enum logic [0:0] {ROW_WRITE, ROW_FRAME} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] value;
      frame_type          samples;
      logic               known;
      limited_frame_type  want;
   } script_row_type;

   typedef enum int {STYLE_QUIET, STYLE_NOISE, STYLE_EXTREME, STYLE_SPIKE, STYLE_TINY} style_type;

   localparam longint GAIN_ONE   = 64'sd16777216;
   localparam longint ROUND_HALF = 64'sd8388608;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HI = 4'd15;
   localparam int N_ROWS        = 27;
   localparam int RANDOM_FRAMES = 900;
   localparam int TAIL_CYCLES   = 60;

   localparam frame_type F_ZERO = '0;

   script_row_type script [N_ROWS] = '{
      '{ROW_FRAME, 4'd0, 24'd0, F_ZERO, 1'b1, '{7'd0, 25'h100_0000, F_ZERO}},
      '{ROW_FRAME, 4'd0, 24'd0, {{6{16'h7FFF}}, 16'hFF9C, 16'h0064}, 1'b1,
        '{7'd0, 25'h100_0000, {96'd0, 16'hFF9C, 16'h0064}}},
      '{ROW_FRAME, 4'd0, 24'd0, {{6{16'h0000}}, 16'h8000, 16'h7FFF}, 1'b0, '0},
      '{ROW_FRAME, 4'd0, 24'd0, F_ZERO, 1'b0, '0},
      '{ROW_WRITE, REG_RELEASE, 24'd0, F_ZERO, 1'b0, '0},
      '{ROW_FRAME, 4'd0, 24'd0, F_ZERO, 1'b0, '0},
      '{ROW_WRITE, REG_ENABLE, 24'd0, F_ZERO, 1'b0, '0},
      '{ROW_FRAME, 4'd0, 24'd0, {4{16'h8000, 16'h7FFF}}, 1'b1,
        '{7'd0, 25'h100_0000, {4{16'h8000, 16'h7FFF}}}},
      '{ROW_WRITE, REG_ENABLE, 24'hFFFFFE, F_ZERO, 1'b0, '0},
      '{ROW_FRAME, 4'd0, 24'd0,
        {16'h0001, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'h00FF, 16'hFF00, 16'h1234, 16'hEDCB},
        1'b1, '{7'd0, 25'h100_0000,
        {16'h0001, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'h00FF, 16'hFF00, 16'h1234, 16'hEDCB}}},
      '{ROW_WRITE, REG_ENABLE, 24'd1, F_ZERO, 1'b0, '0},
      '{ROW_WRITE, REG_CEILING, 24'd0, F_ZERO, 1'b0, '0},
      // zero ceiling: any nonzero peak forces a zero gain
      '{ROW_FRAME, 4'd0, 24'd0, {{7{16'h0000}}, 16'h0001}, 1'b1, '{7'd0, 25'd0, F_ZERO}},
      '{ROW_FRAME, 4'd0, 24'd0, F_ZERO, 1'b0, '0},
      '{ROW_WRITE, REG_CEILING, 24'h007FFF, F_ZERO, 1'b0, '0},
      '{ROW_WRITE, REG_CHANNELS, 24'd0, F_ZERO, 1'b0, '0},
      '{ROW_FRAME, 4'd0, 24'd0, {8{16'h8000}}, 1'b0, '0},
      '{ROW_WRITE, REG_CHANNELS, 24'h00000F, F_ZERO, 1'b0, '0},
      '{ROW_FRAME, 4'd0, 24'd0, {8{16'h8000}}, 1'b0, '0},
      '{ROW_WRITE, REG_RELEASE, 24'hFFFFFF, F_ZERO, 1'b0, '0},
      '{ROW_FRAME, 4'd0, 24'd0, F_ZERO, 1'b0, '0},
      '{ROW_WRITE, REG_UNUSED_LO, 24'hFFFFFF, F_ZERO, 1'b0, '0},
      '{ROW_WRITE, REG_UNUSED_HI, 24'h000000, F_ZERO, 1'b0, '0},
      '{ROW_FRAME, 4'd0, 24'd0,
        {16'h7FFF, 16'h8001, 16'h4000, 16'hC000, 16'h0100, 16'hFF00, 16'h7FFE, 16'h8000},
        1'b0, '0},
      '{ROW_WRITE, REG_CEILING, 24'd8231, F_ZERO, 1'b0, '0},
      '{ROW_WRITE, REG_CHANNELS, 24'd8, F_ZERO, 1'b0, '0},
      '{ROW_FRAME, 4'd0, 24'd0, {{4{16'h7FFF}}, {4{16'h8000}}}, 1'b0, '0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_W-1:0]       req_tdata = '0;   // sample_0 .. sample_7
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_W-1:0]      rsp_tdata;        // limited_0 .. limited_7, applied_gain, pad
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // shadow of the block's registers and gain memory
   logic                  cfg_enable;
   logic [CEIL_W-1:0]     cfg_ceiling;
   logic [COEFF_W-1:0]    cfg_coeff;
   logic [CHAN_W-1:0]     cfg_channels;
   logic [GAIN_W-1:0]     gain_memory;

   limited_frame_type     limited_due [$];
   int                    mismatch_count = 0;
   int                    burst_left = 0;
   int                    gap_max = 0;

   audio_peak_limiter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("audio_peak_limiter_tb: FAIL");
      $finish;
   end

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_ENABLE:   cfg_enable   = value[0];
         REG_CEILING:  cfg_ceiling  = value[CEIL_W-1:0];
         REG_RELEASE:  cfg_coeff    = value[COEFF_W-1:0];
         REG_CHANNELS: cfg_channels = value[CHAN_W-1:0];
         default: ;
      endcase
   endfunction

   // peak detect, instant attack, one-pole release, scale and clip
   function automatic limited_frame_type limit_frame(input frame_type f);
      limited_frame_type r;
      int             n_lanes;
      longint         peak, mag, target, g, c, y, ceil_v;
      r = '0;
      if (!cfg_enable) begin
         r.lane = f;
         r.gain = GAIN_ONE[GAIN_W-1:0];
         return r;
      end
      n_lanes = cfg_channels;
      if (n_lanes < 1) n_lanes = 1;
      if (n_lanes > LANES) n_lanes = LANES;
      peak = 0;
      for (int i = 0; i < n_lanes; i++) begin
         mag = longint'($signed(f[i]));
         if (mag < 0) mag = -mag;
         if (mag > peak) peak = mag;
      end
      ceil_v = cfg_ceiling;
      if (peak > ceil_v) target = (ceil_v <<< 24) / peak;
      else target = GAIN_ONE;
      g = gain_memory;
      if (target < g) begin
         g = target;
      end else begin
         c = cfg_coeff;
         g = (c * g + (GAIN_ONE - c) * target + ROUND_HALF) >>> 24;
      end
      if (g > GAIN_ONE) g = GAIN_ONE;
      gain_memory = g[GAIN_W-1:0];
      for (int i = 0; i < n_lanes; i++) begin
         y = (longint'($signed(f[i])) * g + ROUND_HALF) >>> 24;
         if (y > ceil_v) y = ceil_v;
         if (y < -ceil_v) y = -ceil_v;
         r.lane[i] = y[SAMPLE_W-1:0];
      end
      r.gain = g[GAIN_W-1:0];
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] signed_mag(input int unsigned mag);
      logic [SAMPLE_W-1:0] m;
      m = mag[SAMPLE_W-1:0];
      return ($urandom_range(0, 1) != 0) ? -m : m;
   endfunction

   function automatic frame_type make_frame(input style_type style);
      frame_type   f;
      int unsigned hot;
      logic [SAMPLE_W-1:0] corner [5];
      corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h8001};
      for (int i = 0; i < LANES; i++) begin
         case (style)
            STYLE_QUIET:   f[i] = signed_mag($urandom_range(0, cfg_ceiling));
            STYLE_NOISE:   f[i] = SAMPLE_W'($urandom);
            STYLE_EXTREME: f[i] = corner[$urandom_range(0, 4)];
            STYLE_SPIKE:   f[i] = signed_mag($urandom_range(0, cfg_ceiling / 2));
            default:       f[i] = signed_mag($urandom_range(0, 15));
         endcase
      end
      if (style == STYLE_SPIKE) begin
         hot = $urandom_range(0, LANES - 1);
         f[hot] = signed_mag($urandom_range(cfg_ceiling, 32768));
      end
      return f;
   endfunction

   // bursts of random length separated by random gaps
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         burst_left = $urandom_range(1, 32);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_frame(input frame_type f, input logic known,
                             input limited_frame_type want);
      limited_frame_type predicted;
      pace();
      req_tvalid <= 1'b1;
      req_tdata  <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = limit_frame(f);
      limited_due.push_back(known ? want : predicted);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (limited_due.size() != 0) @(posedge clock);
   endtask

   // valid stays high across a run of writes and is lowered after the last one
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value, input logic more);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(idx, value);
      if (!more) csr_valid <= 1'b0;
   endtask

   // receiver: ready pattern picks a new mode at random intervals
   int ready_mode = 0;
   int ready_hold = 0;
   int ready_tick = 0;
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_hold = $urandom_range(50, 400);
      end
      ready_hold--;
      ready_tick++;
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ((ready_tick % 7) < 2);
      endcase
   end

   always @(posedge clock) begin : check_rsp
      limited_frame_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = limited_frame_type'(rsp_tdata);
         if (limited_due.size() == 0) begin
            mismatch_count++;
            $error("unexpected transaction on rsp, tdata %h", rsp_tdata);
         end else begin
            want = limited_due.pop_front();
            for (int i = 0; i < LANES; i++) begin
               if (got.lane[i] !== want.lane[i]) begin
                  mismatch_count++;
                  $error("limited_%0d: expected %0d, got %0d", i,
                         $signed(want.lane[i]), $signed(got.lane[i]));
               end
            end
            if (got.gain !== want.gain) begin
               mismatch_count++;
               $error("applied_gain: expected %0d, got %0d", want.gain, got.gain);
            end
            if (got.pad !== want.pad) begin
               mismatch_count++;
               $error("pad: expected %0h, got %0h", want.pad, got.pad);
            end
         end
      end
   end

   initial begin
      int             phase, n_frames, random_sent, style_left;
      style_type      style;
      logic           en;
      logic [CEIL_W-1:0]     ceil_pick;
      logic [COEFF_W-1:0]    coeff_pick;
      logic [CHAN_W-1:0]     chan_pick;
      logic [CSR_DATA_W-1:0] word;

      cfg_enable   = RST_ENABLE;
      cfg_ceiling  = RST_CEILING;
      cfg_coeff    = RST_RELEASE;
      cfg_channels = RST_CHANNELS;
      gain_memory  = UNITY_GAIN;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      gap_max = 3;
      for (int r = 0; r < N_ROWS; r++) begin
         if (script[r].kind == ROW_WRITE) begin
            drain();
            write_reg(script[r].index, script[r].value,
                      (r + 1 < N_ROWS) && (script[r + 1].kind == ROW_WRITE));
         end else begin
            send_frame(script[r].samples, script[r].known, script[r].want);
         end
      end

      random_sent = 0;
      phase = 0;
      style = STYLE_QUIET;
      style_left = 0;
      while (random_sent < RANDOM_FRAMES) begin
         drain();
         en = ($urandom_range(0, 7) != 0);
         case ($urandom_range(0, 9))
            0: ceil_pick = CEIL_W'($urandom);
            1: ceil_pick = CEIL_W'($urandom_range(0, 40));
            default: ceil_pick = CEIL_W'($urandom_range(8231, 32767));
         endcase
         case ($urandom_range(0, 3))
            0: coeff_pick = COEFF_W'($urandom_range(16_700_000, 16_777_215));
            1: coeff_pick = COEFF_W'($urandom);
            2: coeff_pick = COEFF_W'($urandom_range(0, 255));
            default: coeff_pick = RST_RELEASE;
         endcase
         chan_pick = CHAN_W'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 8));
         case (phase)
            0: begin
               en = 1'b1; ceil_pick = 15'd8231; coeff_pick = '0; chan_pick = 4'd8;
            end
            1: begin
               en = 1'b1; ceil_pick = 15'd32767; coeff_pick = '1; chan_pick = 4'd1;
            end
            2: en = 1'b0;
            3: begin
               en = 1'b1; ceil_pick = CEIL_W'($urandom_range(0, 40)); chan_pick = 4'd0;
            end
            default: ;
         endcase
         word = CSR_DATA_W'($urandom);
         word[0] = en;
         write_reg(REG_ENABLE, word, 1'b1);
         word = CSR_DATA_W'($urandom);
         word[CEIL_W-1:0] = ceil_pick;
         write_reg(REG_CEILING, word, 1'b1);
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                      CSR_DATA_W'($urandom), 1'b1);
         write_reg(REG_RELEASE, coeff_pick, 1'b1);
         word = CSR_DATA_W'($urandom);
         word[CHAN_W-1:0] = chan_pick;
         write_reg(REG_CHANNELS, word, 1'b0);

         gap_max = (phase % 4 == 1) ? 0 : $urandom_range(1, 24);
         burst_left = 0;
         n_frames = $urandom_range(20, 80);
         for (int k = 0; k < n_frames; k++) begin
            // loud and quiet stretches so the release path gets exercised
            if (style_left == 0) begin
               case ($urandom_range(0, 9))
                  0, 1, 2: style = STYLE_QUIET;
                  3, 4:    style = STYLE_SPIKE;
                  5, 6:    style = STYLE_NOISE;
                  7:       style = STYLE_EXTREME;
                  default: style = STYLE_TINY;
               endcase
               style_left = $urandom_range(1, 12);
            end
            style_left--;
            send_frame(make_frame(style), 1'b0, '0);
            random_sent++;
            if (k == n_frames / 2 && $urandom_range(0, 2) == 0) drain();
         end
         phase++;
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && limited_due.size() == 0) begin
         $display("audio_peak_limiter_tb: PASS");
      end else begin
         $display("audio_peak_limiter_tb: FAIL");
      end
      $finish;
   end

endmodule

>>> audio_peak_limiter.f
hw/rtl/alp_pkg.sv
hw/rtl/alp_dpath.sv
hw/rtl/alp_ctrl.sv
hw/rtl/audio_peak_limiter.sv
sim/audio_peak_limiter_tb.sv
